>>> rtl/core/kmc_pkg.sv
package kmc_pkg;

   // field widths
   localparam int COMMAND_W   = 3;
   localparam int TIME_W      = 32;
   localparam int KEY_INDEX_W = 4;
   localparam int DIRECTION_W = 2;
   localparam int KEY_MASK_W  = 12;
   localparam int MODE_W      = 2;
   localparam int KIND_W      = 3;
   localparam int LEVEL_W     = 7;
   localparam int WINDOW_W    = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // defaults
   localparam int NUM_KEYS_DEFAULT = 12;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 16'd400;
   localparam logic [TIME_W-1:0]   TIMEOUT_RESET = 32'd5000;

   // volume stepping
   localparam logic signed [8:0] VOL_STEP = 9'sd5;
   localparam logic signed [8:0] VOL_MAX  = 9'sd100;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 1'd1;

   // event codes
   typedef enum logic [COMMAND_W-1:0] {
      CMD_KEY_CONFIG = 3'd0,
      CMD_COMPLETE   = 3'd1,
      CMD_CLICK      = 3'd2,
      CMD_KEY_PRESS  = 3'd3,
      CMD_VOLUME     = 3'd4,
      CMD_TICK       = 3'd5
   } cmd_type;

   // message codes
   typedef enum logic [KIND_W-1:0] {
      MSG_NONE     = 3'd0,
      MSG_MUTE_ON  = 3'd1,
      MSG_MUTE_OFF = 3'd2,
      MSG_KEY      = 3'd3,
      MSG_VOLUME   = 3'd4
   } msg_kind_type;

   // mode codes as seen on the result word
   localparam logic [MODE_W-1:0] MODE_INIT      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BACKLIGHT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CMD_WAIT  = 2'd3;

   // controller state, one-hot
   typedef enum logic [3:0] {
      ST_INIT      = 4'b0001,
      ST_NORMAL    = 4'b0010,
      ST_BACKLIGHT = 4'b0100,
      ST_CMD_WAIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [COMMAND_W-1:0]          command;
      logic [TIME_W-1:0]             now_ms;
      logic [KEY_INDEX_W-1:0]        key_index;
      logic signed [DIRECTION_W-1:0] direction;
      logic [KEY_MASK_W-1:0]         key_mask;
   } req_word_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [KIND_W-1:0]  message_kind;
      logic [LEVEL_W-1:0] message_value;
      logic               muted;
      logic [LEVEL_W-1:0] volume;
      logic               awaiting_response;
      logic               init_done;
   } rsp_word_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] double_click_window;
      logic [TIME_W-1:0]   command_timeout;
   } cfg_type;

   function automatic logic [MODE_W-1:0] mode_code(input state_type st);
      logic [MODE_W-1:0] code;
      unique case (st)
         ST_INIT:      code = MODE_INIT;
         ST_NORMAL:    code = MODE_NORMAL;
         ST_BACKLIGHT: code = MODE_BACKLIGHT;
         ST_CMD_WAIT:  code = MODE_CMD_WAIT;
         default:      code = MODE_INIT;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/kmc_if.sv
interface kmc_req_if;
   import kmc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [COMMAND_W-1:0]          command;
   logic [TIME_W-1:0]             now_ms;
   logic [KEY_INDEX_W-1:0]        key_index;
   logic signed [DIRECTION_W-1:0] direction;
   logic [KEY_MASK_W-1:0]         key_mask;

   modport source (output valid, command, now_ms, key_index, direction, key_mask,
                   input ready);
   modport sink (input valid, command, now_ms, key_index, direction, key_mask,
                 output ready);
endinterface

interface kmc_rsp_if;
   import kmc_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [KIND_W-1:0]  message_kind;
   logic [LEVEL_W-1:0] message_value;
   logic               muted;
   logic [LEVEL_W-1:0] volume;
   logic               awaiting_response;
   logic               init_done;

   modport source (output valid, mode, message_kind, message_value, muted, volume,
                   awaiting_response, init_done,
                   input ready);
   modport sink (input valid, mode, message_kind, message_value, muted, volume,
                 awaiting_response, init_done,
                 output ready);
endinterface

>>> rtl/core/kmc_csr.sv
module kmc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [kmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [kmc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output kmc_pkg::cfg_type                  cfg
);
   import kmc_pkg::*;

   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [TIME_W-1:0]   timeout_ff, timeout_in;

   // register write decode
   always_comb begin
      window_in  = window_ff;
      timeout_in = timeout_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW:  window_in  = csr_write_data[WINDOW_W-1:0];
            CSR_TIMEOUT: timeout_in = csr_write_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         window_ff  <= window_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.double_click_window = window_ff;
   assign cfg.command_timeout     = timeout_ff;

endmodule

>>> rtl/core/kmc_fsm.sv
module kmc_fsm #(
   parameter int NUM_KEYS = kmc_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  kmc_pkg::req_word_type req,
   input  kmc_pkg::cfg_type      cfg,
   output kmc_pkg::rsp_word_type rsp
);
   import kmc_pkg::*;

   state_type             state_ff, state_in;
   logic                  pending_ff, pending_in;
   logic [TIME_W-1:0]     last_click_ff, last_click_in;
   logic                  mute_ff, mute_in;
   logic [LEVEL_W-1:0]    volume_ff, volume_in;
   logic [TIME_W-1:0]     cmd_start_ff, cmd_start_in;
   logic [NUM_KEYS-1:0]   assigned_ff, assigned_in;
   logic                  wait_ff, wait_in;
   logic                  cfg_rcvd_ff, cfg_rcvd_in;

   logic [TIME_W-1:0]     since_click;
   logic [TIME_W-1:0]     since_cmd;
   logic                  click_late;
   logic                  cmd_timed_out;
   logic [31:0]           mask_ext;
   logic [31:0]           assigned_ext;
   logic [31:0]           key_sel;
   logic                  key_hit;
   logic signed [8:0]     vol_step;
   logic signed [8:0]     vol_sum;
   logic [LEVEL_W-1:0]    vol_sat;
   msg_kind_type          kind;
   logic [LEVEL_W-1:0]    value;

   // elapsed time compares, wrapping
   assign since_click   = req.now_ms - last_click_ff;
   assign since_cmd     = req.now_ms - cmd_start_ff;
   assign click_late    = since_click > {{(TIME_W-WINDOW_W){1'b0}}, cfg.double_click_window};
   assign cmd_timed_out = since_cmd > cfg.command_timeout;

   // key mask and assigned key lookup
   assign mask_ext     = 32'(req.key_mask);
   assign assigned_ext = 32'(assigned_ff);
   assign key_sel      = assigned_ext >> req.key_index;
   assign key_hit      = (32'(req.key_index) < 32'(NUM_KEYS)) && key_sel[0];

   // volume step with saturation
   always_comb begin
      unique case (req.direction)
         2'b01:   vol_step = VOL_STEP;
         2'b11:   vol_step = -VOL_STEP;
         2'b10:   vol_step = -(VOL_STEP <<< 1);
         default: vol_step = 9'sd0;
      endcase
      vol_sum = $signed({2'b00, volume_ff}) + vol_step;
      if (vol_sum < 9'sd0) begin
         vol_sat = '0;
      end else if (vol_sum > VOL_MAX) begin
         vol_sat = VOL_MAX[LEVEL_W-1:0];
      end else begin
         vol_sat = vol_sum[LEVEL_W-1:0];
      end
   end

   // per-event state update
   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      last_click_in = last_click_ff;
      mute_in       = mute_ff;
      volume_in     = volume_ff;
      cmd_start_in  = cmd_start_ff;
      assigned_in   = assigned_ff;
      wait_in       = wait_ff;
      cfg_rcvd_in   = cfg_rcvd_ff;
      kind          = MSG_NONE;
      value         = '0;

      unique case (state_ff)
         ST_INIT: begin
            if (req.command == CMD_KEY_CONFIG) begin
               assigned_in   = mask_ext[NUM_KEYS-1:0];
               cfg_rcvd_in   = 1'b1;
               state_in      = ST_NORMAL;
               pending_in    = 1'b0;
               last_click_in = '0;
            end
         end
         ST_NORMAL: begin
            if (req.command == CMD_CLICK) begin
               if (pending_ff) begin
                  if (!click_late) begin
                     state_in      = ST_BACKLIGHT;
                     pending_in    = 1'b0;
                     last_click_in = '0;
                  end
               end else if (click_late) begin
                  mute_in       = !mute_ff;
                  kind          = mute_ff ? MSG_MUTE_OFF : MSG_MUTE_ON;
                  pending_in    = 1'b1;
                  last_click_in = req.now_ms;
               end
            end else if (req.command == CMD_KEY_PRESS) begin
               if (key_hit) begin
                  kind         = MSG_KEY;
                  value        = LEVEL_W'(req.key_index);
                  cmd_start_in = req.now_ms;
                  wait_in      = 1'b1;
                  state_in     = ST_CMD_WAIT;
               end
            end else if (req.command == CMD_VOLUME) begin
               volume_in = vol_sat;
               kind      = MSG_VOLUME;
               value     = vol_sat;
            end else if (req.command == CMD_TICK) begin
               if (pending_ff && click_late) begin
                  pending_in = 1'b0;
               end
            end
         end
         ST_BACKLIGHT: begin
            if (req.command == CMD_CLICK) begin
               if (pending_ff) begin
                  if (!click_late) begin
                     state_in      = ST_NORMAL;
                     pending_in    = 1'b0;
                     last_click_in = '0;
                  end
               end else begin
                  pending_in    = 1'b1;
                  last_click_in = req.now_ms;
               end
            end else if (req.command == CMD_TICK) begin
               if (pending_ff && click_late) begin
                  pending_in = 1'b0;
               end
            end
         end
         ST_CMD_WAIT: begin
            if (req.command == CMD_COMPLETE || (req.command == CMD_TICK && cmd_timed_out)) begin
               wait_in       = 1'b0;
               state_in      = ST_NORMAL;
               pending_in    = 1'b0;
               last_click_in = '0;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // state registers, updated once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         pending_ff    <= 1'b0;
         last_click_ff <= '0;
         mute_ff       <= 1'b0;
         volume_ff     <= '0;
         cmd_start_ff  <= '0;
         assigned_ff   <= '0;
         wait_ff       <= 1'b0;
         cfg_rcvd_ff   <= 1'b0;
      end else if (advance) begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         last_click_ff <= last_click_in;
         mute_ff       <= mute_in;
         volume_ff     <= volume_in;
         cmd_start_ff  <= cmd_start_in;
         assigned_ff   <= assigned_in;
         wait_ff       <= wait_in;
         cfg_rcvd_ff   <= cfg_rcvd_in;
      end
   end

   // result word reflects state after the event
   assign rsp.mode              = mode_code(state_in);
   assign rsp.message_kind      = kind;
   assign rsp.message_value     = value;
   assign rsp.muted             = mute_in;
   assign rsp.volume            = volume_in;
   assign rsp.awaiting_response = wait_in;
   assign rsp.init_done         = cfg_rcvd_in;

endmodule

>>> rtl/core/keypad_mode_controller.sv
// Mode controller for a macro keypad: each request word is one timestamped event
// (key config, command complete, encoder click, key press, volume turn, tick) and
// yields exactly one response word with the mode, any message and the status
// after that event. One word is accepted per clock unless a stalled response holds
// the input register. The event is evaluated out of the input register and the
// result lands in the output register on the same edge as the state registers
// update. A stalled response holds at most one more word in the input register
// before the request side stalls. The user must write the double click window and
// the command timeout through the csr port only while no event is in flight; the
// block itself does not enforce this. No memory clearing is needed after reset.
module keypad_mode_controller #(
   parameter int NUM_KEYS = kmc_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   kmc_req_if.sink                         req_if,
   kmc_rsp_if.source                       rsp_if,
   input  logic                            csr_write_enable,
   input  logic [kmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kmc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import kmc_pkg::*;

   req_word_type in_word_ff, in_word_in;
   logic         in_valid_ff, in_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   logic         req_take;
   cfg_type      cfg;
   rsp_word_type step_rsp;

   kmc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   kmc_fsm #(
      .NUM_KEYS (NUM_KEYS)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_word_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // pipeline flow control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in          = 1'b1;
         in_word_in.command   = req_if.command;
         in_word_in.now_ms    = req_if.now_ms;
         in_word_in.key_index = req_if.key_index;
         in_word_in.direction = req_if.direction;
         in_word_in.key_mask  = req_if.key_mask;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in  = step_rsp;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.mode              = out_word_ff.mode;
   assign rsp_if.message_kind      = out_word_ff.message_kind;
   assign rsp_if.message_value     = out_word_ff.message_value;
   assign rsp_if.muted             = out_word_ff.muted;
   assign rsp_if.volume            = out_word_ff.volume;
   assign rsp_if.awaiting_response = out_word_ff.awaiting_response;
   assign rsp_if.init_done         = out_word_ff.init_done;

endmodule
